@@ src/rmsig_pkg.sv @@
// Shared constants and sequencer state type for the running mean/sigma block.
`default_nettype none

package rmsig_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 20;

  localparam int IN_W      = 16;
  localparam int MEAN_W    = 32;
  localparam int MEAN_FRAC = MEAN_W - SAMPLE_BITS;
  localparam int M2_W      = 60;
  localparam int M2_SHIFT  = 2 * MEAN_FRAC - 8;
  localparam int OUT_W     = 24;
  localparam int CNT_W     = COUNT_BITS + 1;
  localparam int PROD_W    = 2 * MEAN_W;

  // shared divider: widest dividend is M2 with 8 extra fraction bits
  localparam int DIV_W     = M2_W + 8;
  localparam int DCNT_W    = $clog2(DIV_W + 1);

  // square root works on a 2*OUT_W bit radicand, one result bit per step
  localparam int SQ_W      = 2 * OUT_W;
  localparam int SQ_STEPS  = OUT_W;
  localparam int SCNT_W    = $clog2(SQ_STEPS + 1);

  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(1) << COUNT_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SDIV,
    ST_MEAN,
    ST_DEV,
    ST_MUL,
    ST_ACC,
    ST_OLOAD,
    ST_ODIV,
    ST_RLOAD,
    ST_ROOT,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

@@ src/running_mean_sigma.sv @@
// Running mean and population sigma over sample sets, Welford update, shared serial divider.
`default_nettype none

// Each request is one sample; the block stalls its input while it works on it.
// A sample that is not the last of its set is taken, then runs 32 steps of the
// shared restoring divider (mean correction d/n), then mean update, deviation,
// one 32x32 multiply and the saturating M2 add. A last sample adds 68 divider
// steps for M2*256/n and 24 square root steps, then the result is loaded into
// the output register. A sample that arrives with the count at its limit is
// dropped (or goes straight to the result phase when it closes the set). The
// output register lets the next sample in while a result waits to be taken.
module running_mean_sigma (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rmsig_pkg::IN_W-1:0]    in_sample,
  input  wire logic                          in_last_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rmsig_pkg::OUT_W-1:0]        out_mean_value,
  output logic [rmsig_pkg::OUT_W-1:0]        out_sigma_value,
  output logic [rmsig_pkg::CNT_W-1:0]        out_sample_count,
  output logic                               out_overflowed
);

  localparam int MEAN_W = rmsig_pkg::MEAN_W;
  localparam int M2_W   = rmsig_pkg::M2_W;
  localparam int OUT_W  = rmsig_pkg::OUT_W;
  localparam int CNT_W  = rmsig_pkg::CNT_W;
  localparam int DIV_W  = rmsig_pkg::DIV_W;
  localparam int DCNT_W = rmsig_pkg::DCNT_W;
  localparam int SQ_W   = rmsig_pkg::SQ_W;
  localparam int SCNT_W = rmsig_pkg::SCNT_W;
  localparam int PROD_W = rmsig_pkg::PROD_W;

  rmsig_pkg::state_t state_r, state_nxt;

  logic [MEAN_W-1:0] mean_r, mean_nxt;
  logic [M2_W-1:0]   m2_r, m2_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic              last_r, last_nxt;

  logic [MEAN_W-1:0] xs_r, xs_nxt;
  logic              neg_r, neg_nxt;
  logic [MEAN_W-1:0] d_r, d_nxt;
  logic [MEAN_W-1:0] e_r, e_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;

  logic [DIV_W-1:0]  num_r, num_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  den_r, den_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;

  logic [SQ_W-1:0]   sqv_r, sqv_nxt;
  logic [SQ_W-1:0]   sqres_r, sqres_nxt;
  logic [SQ_W-1:0]   sqbit_r, sqbit_nxt;
  logic [SCNT_W-1:0] scnt_r, scnt_nxt;
  logic [OUT_W-1:0]  sig_r, sig_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_mean_r, out_mean_nxt;
  logic [OUT_W-1:0]  out_sig_r, out_sig_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              in_acc;
  logic              room;
  logic              out_free;
  logic [MEAN_W-1:0] in_xs;

  // divider step
  logic [CNT_W:0]    div_trial;
  logic              div_ge;
  logic [CNT_W:0]    div_diff;
  logic [CNT_W-1:0]  div_rem;
  logic [DIV_W-1:0]  div_num;

  // square root step
  logic [SQ_W:0]     sq_sum;
  logic              sq_ge;
  logic [SQ_W-1:0]   sq_v;
  logic [SQ_W-1:0]   sq_res;

  // M2 accumulate and output shaping
  logic [PROD_W-1:0] prod_sh;
  logic [PROD_W:0]   m2_sum;
  logic [MEAN_W-1:0] mean_sh;
  logic [OUT_W-1:0]  mean_q8;

  assign in_stall = (state_r != rmsig_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign room     = (count_r < rmsig_pkg::COUNT_LIMIT);
  assign out_free = !out_valid_r || !out_stall;
  assign in_xs    = {in_sample[rmsig_pkg::SAMPLE_BITS-1:0], rmsig_pkg::MEAN_FRAC'(0)};

  assign div_trial = {rem_r, num_r[DIV_W-1]};
  assign div_ge    = (div_trial >= {1'b0, den_r});
  assign div_diff  = div_trial - {1'b0, den_r};
  assign div_rem   = div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
  assign div_num   = {num_r[DIV_W-2:0], div_ge};

  assign sq_sum = {1'b0, sqres_r} + {1'b0, sqbit_r};
  assign sq_ge  = ({1'b0, sqv_r} >= sq_sum);
  assign sq_v   = sq_ge ? (sqv_r - sq_sum[SQ_W-1:0]) : sqv_r;
  assign sq_res = sq_ge ? ((sqres_r >> 1) + sqbit_r) : (sqres_r >> 1);

  assign prod_sh = prod_r >> rmsig_pkg::M2_SHIFT;
  assign m2_sum  = {1'b0, prod_sh} + (PROD_W + 1)'(m2_r);
  assign mean_sh = mean_r >> (rmsig_pkg::MEAN_FRAC - 8);
  assign mean_q8 = (|mean_sh[MEAN_W-1:OUT_W]) ? '1 : mean_sh[OUT_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rmsig_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (room) begin
            state_nxt = rmsig_pkg::ST_SDIV;
          end else if (in_last_sample) begin
            state_nxt = rmsig_pkg::ST_OLOAD;
          end
        end
      end
      rmsig_pkg::ST_SDIV: begin
        if (dcnt_r == DCNT_W'(1)) state_nxt = rmsig_pkg::ST_MEAN;
      end
      rmsig_pkg::ST_MEAN: state_nxt = rmsig_pkg::ST_DEV;
      rmsig_pkg::ST_DEV:  state_nxt = rmsig_pkg::ST_MUL;
      rmsig_pkg::ST_MUL:  state_nxt = rmsig_pkg::ST_ACC;
      rmsig_pkg::ST_ACC: begin
        state_nxt = last_r ? rmsig_pkg::ST_OLOAD : rmsig_pkg::ST_IDLE;
      end
      rmsig_pkg::ST_OLOAD: begin
        state_nxt = (count_r == '0) ? rmsig_pkg::ST_OUT : rmsig_pkg::ST_ODIV;
      end
      rmsig_pkg::ST_ODIV: begin
        if (dcnt_r == DCNT_W'(1)) state_nxt = rmsig_pkg::ST_RLOAD;
      end
      rmsig_pkg::ST_RLOAD: begin
        state_nxt = (|num_r[DIV_W-1:SQ_W]) ? rmsig_pkg::ST_OUT : rmsig_pkg::ST_ROOT;
      end
      rmsig_pkg::ST_ROOT: begin
        if (scnt_r == SCNT_W'(1)) state_nxt = rmsig_pkg::ST_OUT;
      end
      rmsig_pkg::ST_OUT: begin
        if (out_free) state_nxt = rmsig_pkg::ST_IDLE;
      end
      default: state_nxt = rmsig_pkg::ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    mean_nxt      = mean_r;
    m2_nxt        = m2_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    xs_nxt        = xs_r;
    neg_nxt       = neg_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    prod_nxt      = prod_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    dcnt_nxt      = dcnt_r;
    sqv_nxt       = sqv_r;
    sqres_nxt     = sqres_r;
    sqbit_nxt     = sqbit_r;
    scnt_nxt      = scnt_r;
    sig_nxt       = sig_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_mean_nxt  = out_mean_r;
    out_sig_nxt   = out_sig_r;
    out_cnt_nxt   = out_cnt_r;
    out_ovf_nxt   = out_ovf_r;

    unique case (state_r)
      rmsig_pkg::ST_IDLE: begin
        if (in_acc) begin
          last_nxt = in_last_sample;
          if (room) begin
            xs_nxt   = in_xs;
            neg_nxt  = (in_xs < mean_r);
            d_nxt    = (in_xs < mean_r) ? (mean_r - in_xs) : (in_xs - mean_r);
            num_nxt  = {((in_xs < mean_r) ? (mean_r - in_xs) : (in_xs - mean_r)),
                        (DIV_W - MEAN_W)'(0)};
            rem_nxt  = '0;
            den_nxt  = count_r + CNT_W'(1);
            dcnt_nxt = DCNT_W'(MEAN_W);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      rmsig_pkg::ST_SDIV, rmsig_pkg::ST_ODIV: begin
        num_nxt  = div_num;
        rem_nxt  = div_rem;
        dcnt_nxt = dcnt_r - DCNT_W'(1);
      end
      rmsig_pkg::ST_MEAN: begin
        mean_nxt  = neg_r ? (mean_r - num_r[MEAN_W-1:0]) : (mean_r + num_r[MEAN_W-1:0]);
        count_nxt = den_r;
      end
      rmsig_pkg::ST_DEV: begin
        e_nxt = neg_r ? (mean_r - xs_r) : (xs_r - mean_r);
      end
      rmsig_pkg::ST_MUL: begin
        prod_nxt = d_r * e_r;
      end
      rmsig_pkg::ST_ACC: begin
        m2_nxt = (m2_sum > (PROD_W + 1)'({M2_W{1'b1}})) ? '1 : m2_sum[M2_W-1:0];
      end
      rmsig_pkg::ST_OLOAD: begin
        // empty set cannot really occur; report zero sigma for it
        sig_nxt  = '0;
        num_nxt  = {m2_r, 8'd0};
        rem_nxt  = '0;
        den_nxt  = count_r;
        dcnt_nxt = DCNT_W'(DIV_W);
      end
      rmsig_pkg::ST_RLOAD: begin
        // quotient at or above 2^48 means sigma saturates
        sig_nxt   = '1;
        sqv_nxt   = num_r[SQ_W-1:0];
        sqres_nxt = '0;
        sqbit_nxt = SQ_W'(1) << (SQ_W - 2);
        scnt_nxt  = SCNT_W'(rmsig_pkg::SQ_STEPS);
      end
      rmsig_pkg::ST_ROOT: begin
        sqv_nxt   = sq_v;
        sqres_nxt = sq_res;
        sqbit_nxt = sqbit_r >> 2;
        scnt_nxt  = scnt_r - SCNT_W'(1);
        if (scnt_r == SCNT_W'(1)) sig_nxt = sq_res[OUT_W-1:0];
      end
      rmsig_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = mean_q8;
          out_sig_nxt   = sig_r;
          out_cnt_nxt   = count_r;
          out_ovf_nxt   = ovf_r;
          mean_nxt      = '0;
          m2_nxt        = '0;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmsig_pkg::ST_IDLE;
      mean_r      <= '0;
      m2_r        <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mean_r      <= mean_nxt;
      m2_r        <= m2_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    xs_r       <= xs_nxt;
    neg_r      <= neg_nxt;
    d_r        <= d_nxt;
    e_r        <= e_nxt;
    prod_r     <= prod_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    dcnt_r     <= dcnt_nxt;
    sqv_r      <= sqv_nxt;
    sqres_r    <= sqres_nxt;
    sqbit_r    <= sqbit_nxt;
    scnt_r     <= scnt_nxt;
    sig_r      <= sig_nxt;
    out_mean_r <= out_mean_nxt;
    out_sig_r  <= out_sig_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_mean_value   = out_mean_r;
  assign out_sigma_value  = out_sig_r;
  assign out_sample_count = out_cnt_r;
  assign out_overflowed   = out_ovf_r;

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rmsig_pkg::COUNT_LIMIT)
    else $error("sample count past its limit");

  a_sample_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && room) |=> (state_r == rmsig_pkg::ST_SDIV))
    else $error("accepted sample did not start the divider");

  a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !room) |=> ovf_r || (state_r == rmsig_pkg::ST_OLOAD && ovf_r))
    else $error("dropped sample did not raise overflow");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmsig_pkg::ST_OUT && out_free) |=> (out_valid_r && count_r == '0))
    else $error("result load did not clear the set");

endmodule

`default_nettype wire
